// ===== rtl/fsm_pkg.sv =====
// shared types, operation codes and stack effect tables of the forth core
`default_nettype none
package fsm_pkg;

  localparam logic [5:0] K_PUSH    = 6'd0;
  localparam logic [5:0] K_LOAD    = 6'd1;
  localparam logic [5:0] K_STORE   = 6'd2;
  localparam logic [5:0] K_LT      = 6'd3;
  localparam logic [5:0] K_GT      = 6'd4;
  localparam logic [5:0] K_EQ      = 6'd5;
  localparam logic [5:0] K_ADD     = 6'd6;
  localparam logic [5:0] K_SUB     = 6'd7;
  localparam logic [5:0] K_MUL     = 6'd8;
  localparam logic [5:0] K_DIV     = 6'd9;
  localparam logic [5:0] K_XOR     = 6'd10;
  localparam logic [5:0] K_LAND    = 6'd11;
  localparam logic [5:0] K_LOR     = 6'd12;
  localparam logic [5:0] K_LNOT    = 6'd13;
  localparam logic [5:0] K_BRTEST  = 6'd14;
  localparam logic [5:0] K_PRINTI  = 6'd15;
  localparam logic [5:0] K_PRINTC  = 6'd16;
  localparam logic [5:0] K_DUP     = 6'd17;
  localparam logic [5:0] K_DROP    = 6'd18;
  localparam logic [5:0] K_SWAP    = 6'd19;
  localparam logic [5:0] K_OVER    = 6'd20;
  localparam logic [5:0] K_ROT     = 6'd21;
  localparam logic [5:0] K_MROT    = 6'd22;
  localparam logic [5:0] K_PICK    = 6'd23;
  localparam logic [5:0] K_QDUP    = 6'd24;
  localparam logic [5:0] K_2DUP    = 6'd25;
  localparam logic [5:0] K_2OVER   = 6'd26;
  localparam logic [5:0] K_2SWAP   = 6'd27;
  localparam logic [5:0] K_TOR     = 6'd28;
  localparam logic [5:0] K_RFROM   = 6'd29;
  localparam logic [5:0] K_RFETCH  = 6'd30;
  localparam logic [5:0] K_2TOR    = 6'd31;
  localparam logic [5:0] K_2RFROM  = 6'd32;
  localparam logic [5:0] K_2RFETCH = 6'd33;
  localparam logic [5:0] K_MEMSIZE = 6'd34;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DUNDER  = 3'd1;
  localparam logic [2:0] ST_DOVER   = 3'd2;
  localparam logic [2:0] ST_RUNDER  = 3'd3;
  localparam logic [2:0] ST_ROVER   = 3'd4;
  localparam logic [2:0] ST_BADADDR = 3'd5;
  localparam logic [2:0] ST_DIVZERO = 3'd6;

  localparam int CELL_W = 64;
  localparam int MEMW_W = 13;

  typedef struct packed {
    logic [5:0]               kind;
    logic signed [CELL_W-1:0] literal;
  } in_t;

  typedef struct packed {
    logic [2:0]               status;
    logic                     emit_valid;
    logic                     emit_is_char;
    logic signed [CELL_W-1:0] emit_value;
    logic                     popped_zero;
    logic [8:0]               data_depth;
  } out_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_rsp_t;

  function automatic logic [2:0] d_need(input logic [5:0] k);
    case (k) inside
      K_PUSH, K_RFROM, K_RFETCH, K_2RFROM, K_2RFETCH, K_MEMSIZE: d_need = 3'd0;
      K_LOAD, K_LNOT, K_BRTEST, K_PRINTI, K_PRINTC, K_DUP, K_DROP,
      K_PICK, K_QDUP, K_TOR:                                      d_need = 3'd1;
      K_ROT, K_MROT:                                              d_need = 3'd3;
      K_2OVER, K_2SWAP:                                           d_need = 3'd4;
      default:                                                    d_need = 3'd2;
    endcase
  endfunction

  function automatic logic [2:0] d_give(input logic [5:0] k);
    case (k) inside
      K_STORE, K_BRTEST, K_PRINTI, K_PRINTC, K_DROP, K_TOR, K_2TOR: d_give = 3'd0;
      K_DUP, K_SWAP, K_2RFROM, K_2RFETCH:                          d_give = 3'd2;
      K_OVER, K_ROT, K_MROT:                                       d_give = 3'd3;
      K_2DUP, K_2SWAP:                                             d_give = 3'd4;
      K_2OVER:                                                     d_give = 3'd6;
      default:                                                     d_give = 3'd1;
    endcase
  endfunction

  function automatic logic [1:0] r_need(input logic [5:0] k);
    case (k) inside
      K_RFROM, K_RFETCH:   r_need = 2'd1;
      K_2RFROM, K_2RFETCH: r_need = 2'd2;
      default:             r_need = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] r_give(input logic [5:0] k);
    case (k) inside
      K_TOR, K_RFETCH:    r_give = 2'd1;
      K_2TOR, K_2RFETCH:  r_give = 2'd2;
      default:            r_give = 2'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== rtl/fsm_muldiv.sv =====
// iterative multiplier and signed truncating divider, one bit per cycle
`default_nettype none
module fsm_muldiv (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire fsm_pkg::md_req_t             req,
  input  wire logic [fsm_pkg::CELL_W-1:0]   a,
  input  wire logic [fsm_pkg::CELL_W-1:0]   b,
  output fsm_pkg::md_rsp_t                  rsp,
  output logic [fsm_pkg::CELL_W-1:0]        result
);
  import fsm_pkg::*;

  localparam int CNT_W = $clog2(CELL_W);

  logic              busy_r, fin_r, done_r, is_div_r, neg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CELL_W-1:0] x_r, y_r, acc_r, res_r;
  logic [CELL_W-1:0] rem_s;
  logic              ge;

  // shifted remainder and trial subtract compare
  assign rem_s = {acc_r[CELL_W-2:0], x_r[CELL_W-1]};
  assign ge    = (rem_s >= y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r && !fin_r) begin
        busy_r   <= 1'b1;
        cnt_r    <= '0;
        is_div_r <= req.is_div;
        acc_r    <= '0;
        neg_r    <= a[CELL_W-1] ^ b[CELL_W-1];
        if (req.is_div) begin
          x_r <= a[CELL_W-1] ? (CELL_W'(0) - a) : a;
          y_r <= b[CELL_W-1] ? (CELL_W'(0) - b) : b;
        end else begin
          x_r <= a;
          y_r <= b;
        end
      end else if (busy_r) begin
        if (is_div_r) begin
          x_r   <= {x_r[CELL_W-2:0], ge};
          acc_r <= ge ? (rem_s - y_r) : rem_s;
        end else begin
          if (y_r[0]) acc_r <= acc_r + x_r;
          x_r <= {x_r[CELL_W-2:0], 1'b0};
          y_r <= {1'b0, y_r[CELL_W-1:1]};
        end
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(CELL_W-1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        // sign fixup of the quotient, most negative over minus one wraps
        res_r  <= is_div_r ? (neg_r ? (CELL_W'(0) - x_r) : x_r) : acc_r;
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign rsp.busy = busy_r | fin_r;
  assign rsp.done = done_r;
  assign result   = res_r;

endmodule
`default_nettype wire

// ===== rtl/forth_stack_machine_core.sv =====
// top level of the two-stack forth execution core
`default_nettype none
// Two-stack Forth execution core. Each request carries one operation; the core
// answers it with exactly one result holding a status code, print data, a branch
// flag and the data stack depth. Data stack, return stack and data memory are
// synchronous single-read memories with registered read data, and a
// sequencer walks every operation through check, read, execute, write back and
// result, so the core works on one request at a time. Load and pick take an
// extra capture step after execute. Unknown operations and stack faults go from
// check straight to the result step. Multiply and divide go through a
// bit-serial unit. After reset the data memory is cleared by a pass over every
// word during which no request is accepted; register writes are taken at any
// time. A finished result sits in an output register, so the next request is
// taken while the previous result is still waiting.
module forth_stack_machine_core #(
  parameter int DSTACK_DEPTH = 256,
  parameter int RSTACK_DEPTH = 64,
  parameter int MEM_DEPTH    = 4096
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire fsm_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output fsm_pkg::out_t       out_data,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import fsm_pkg::*;

  localparam int DCW  = $clog2(DSTACK_DEPTH + 1);
  localparam int DAW  = $clog2(DSTACK_DEPTH);
  localparam int RCW  = $clog2(RSTACK_DEPTH + 1);
  localparam int RAW  = $clog2(RSTACK_DEPTH);
  localparam int MAW  = $clog2(MEM_DEPTH);
  localparam int MLW  = $clog2(MEM_DEPTH + 1);
  localparam int LW   = (MLW > MEMW_W) ? MLW : MEMW_W;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CHECK, S_DRD, S_DCAP, S_RRD, S_RCAP,
    S_EXEC, S_XCAP, S_MD, S_COMP, S_DWR, S_RWR, S_OUT
  } state_t;

  state_t            state_r;
  logic [5:0]        kind_r;
  logic [CELL_W-1:0] lit_r;
  logic [DCW-1:0]    dcnt_r;
  logic [RCW-1:0]    rcnt_r;
  logic [MEMW_W-1:0] memw_r;
  logic [2:0]        st_r;
  logic [2:0]        i_r;
  logic [2:0]        give_r;
  logic [CELL_W-1:0] p_r [4];
  logic [CELL_W-1:0] q_r [2];
  logic [CELL_W-1:0] x_r;
  logic [CELL_W-1:0] res_r [6];
  logic [MAW-1:0]    clr_cnt_r;
  logic              out_valid_r;
  out_t              out_r;

  // stack and data memories
  logic [CELL_W-1:0] ds_mem  [DSTACK_DEPTH];
  logic [CELL_W-1:0] rs_mem  [RSTACK_DEPTH];
  logic [CELL_W-1:0] dat_mem [MEM_DEPTH];
  logic [CELL_W-1:0] ds_rdata_r, rs_rdata_r, mem_rdata_r;

  logic [DAW-1:0]    ds_raddr, ds_waddr;
  logic [RAW-1:0]    rs_raddr, rs_waddr;
  logic [MAW-1:0]    mem_addr;
  logic              ds_we, rs_we, mem_we;
  logic [CELL_W-1:0] ds_wdata, rs_wdata, mem_wdata;

  // per operation stack effects
  logic [2:0]        need_c;
  logic [2:0]        give_c;
  logic [1:0]        rneed_c;
  logic [1:0]        rgive_c;
  logic [DCW:0]      d_after;
  logic [RCW:0]      r_after;
  logic [LW-1:0]     limit;
  logic              addr_ok, pick_ok;
  logic [DCW-1:0]    pick_idx;
  logic [CELL_W-1:0] res_c [6];
  logic [CELL_W-1:0] rrv_c [2];
  logic              is_print, ok_c;

  md_req_t           md_req;
  md_rsp_t           md_rsp;
  logic [CELL_W-1:0] md_res;

  assign need_c  = d_need(kind_r);
  assign give_c  = d_give(kind_r);
  assign rneed_c = r_need(kind_r);
  assign rgive_c = r_give(kind_r);
  assign d_after = (DCW+1)'(dcnt_r) - (DCW+1)'(need_c) + (DCW+1)'(give_c);
  assign r_after = (RCW+1)'(rcnt_r) - (RCW+1)'(rneed_c) + (RCW+1)'(rgive_c);

  // effective memory size is the smaller of the register and the array
  assign limit    = (LW'(memw_r) < LW'(MEM_DEPTH)) ? LW'(memw_r) : LW'(MEM_DEPTH);
  assign addr_ok  = p_r[0] < CELL_W'(limit);
  assign pick_ok  = p_r[0] < CELL_W'(dcnt_r - DCW'(1));
  assign pick_idx = dcnt_r - DCW'(2) - p_r[0][DCW-1:0];

  // memory addressing by sequencer step
  assign ds_raddr  = (state_r == S_EXEC) ? pick_idx[DAW-1:0]
                   : DAW'(dcnt_r - DCW'(1) - DCW'(i_r));
  assign rs_raddr  = RAW'(rcnt_r - RCW'(1) - RCW'(i_r));
  assign ds_we     = (state_r == S_DWR) && (i_r < give_r);
  assign ds_waddr  = DAW'(dcnt_r - DCW'(need_c) + DCW'(i_r));
  assign ds_wdata  = res_r[i_r];
  assign rs_we     = (state_r == S_RWR) && (i_r < {1'b0, rgive_c});
  assign rs_waddr  = RAW'(rcnt_r - RCW'(rneed_c) + RCW'(i_r));
  assign rs_wdata  = rrv_c[i_r[0]];
  assign mem_we    = (state_r == S_CLR)
                   || ((state_r == S_EXEC) && (kind_r == K_STORE) && addr_ok);
  assign mem_addr  = (state_r == S_CLR) ? clr_cnt_r : p_r[0][MAW-1:0];
  assign mem_wdata = (state_r == S_CLR) ? '0 : p_r[1];

  always_ff @(posedge clk) begin
    if (ds_we) ds_mem[ds_waddr] <= ds_wdata;
    ds_rdata_r <= ds_mem[ds_raddr];
  end

  always_ff @(posedge clk) begin
    if (rs_we) rs_mem[rs_waddr] <= rs_wdata;
    rs_rdata_r <= rs_mem[rs_raddr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) dat_mem[mem_addr] <= mem_wdata;
    mem_rdata_r <= dat_mem[mem_addr];
  end

  // multiply and divide on second (a) and top (b)
  assign md_req.start  = (state_r == S_EXEC)
                       && ((kind_r == K_MUL) || ((kind_r == K_DIV) && (p_r[0] != '0)));
  assign md_req.is_div = (kind_r == K_DIV);

  fsm_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (md_req),
    .a      (p_r[1]),
    .b      (p_r[0]),
    .rsp    (md_rsp),
    .result (md_res)
  );

  // cells pushed back on the data stack, deepest first
  always_comb begin
    for (int k = 0; k < 6; k++) res_c[k] = '0;
    case (kind_r)
      K_PUSH:    res_c[0] = lit_r;
      K_LOAD, K_MUL, K_DIV, K_PICK: res_c[0] = x_r;
      K_LT:      res_c[0] = CELL_W'($signed(p_r[1]) < $signed(p_r[0]));
      K_GT:      res_c[0] = CELL_W'($signed(p_r[0]) < $signed(p_r[1]));
      K_EQ:      res_c[0] = CELL_W'(p_r[0] == p_r[1]);
      K_ADD:     res_c[0] = p_r[1] + p_r[0];
      K_SUB:     res_c[0] = p_r[1] - p_r[0];
      K_XOR:     res_c[0] = p_r[1] ^ p_r[0];
      K_LAND:    res_c[0] = CELL_W'((p_r[0] != '0) && (p_r[1] != '0));
      K_LOR:     res_c[0] = CELL_W'((p_r[0] != '0) || (p_r[1] != '0));
      K_LNOT:    res_c[0] = CELL_W'(p_r[0] == '0);
      K_DUP, K_QDUP: begin
        res_c[0] = p_r[0];
        res_c[1] = p_r[0];
      end
      K_SWAP: begin
        res_c[0] = p_r[0];
        res_c[1] = p_r[1];
      end
      K_OVER: begin
        res_c[0] = p_r[1];
        res_c[1] = p_r[0];
        res_c[2] = p_r[1];
      end
      K_ROT: begin
        res_c[0] = p_r[1];
        res_c[1] = p_r[0];
        res_c[2] = p_r[2];
      end
      K_MROT: begin
        res_c[0] = p_r[0];
        res_c[1] = p_r[2];
        res_c[2] = p_r[1];
      end
      K_2DUP: begin
        res_c[0] = p_r[1];
        res_c[1] = p_r[0];
        res_c[2] = p_r[1];
        res_c[3] = p_r[0];
      end
      K_2OVER: begin
        res_c[0] = p_r[3];
        res_c[1] = p_r[2];
        res_c[2] = p_r[1];
        res_c[3] = p_r[0];
        res_c[4] = p_r[3];
        res_c[5] = p_r[2];
      end
      K_2SWAP: begin
        res_c[0] = p_r[1];
        res_c[1] = p_r[0];
        res_c[2] = p_r[3];
        res_c[3] = p_r[2];
      end
      K_RFROM, K_RFETCH: res_c[0] = q_r[0];
      K_2RFROM, K_2RFETCH: begin
        res_c[0] = q_r[1];
        res_c[1] = q_r[0];
      end
      K_MEMSIZE: res_c[0] = CELL_W'(limit);
      default: ;
    endcase
  end

  // cells pushed on the return stack, deepest first
  always_comb begin
    rrv_c[0] = '0;
    rrv_c[1] = '0;
    case (kind_r)
      K_TOR:     rrv_c[0] = p_r[0];
      K_RFETCH:  rrv_c[0] = q_r[0];
      K_2TOR: begin
        rrv_c[0] = p_r[1];
        rrv_c[1] = p_r[0];
      end
      K_2RFETCH: begin
        rrv_c[0] = q_r[1];
        rrv_c[1] = q_r[0];
      end
      default: ;
    endcase
  end

  assign ok_c     = (st_r == ST_OK);
  assign is_print = (kind_r == K_PRINTI) || (kind_r == K_PRINTC);

  // sequencer: all memory writes of one request land before the next one reads,
  // so no forwarding is needed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      dcnt_r      <= '0;
      rcnt_r      <= '0;
      memw_r      <= MEMW_W'(4096);
      out_valid_r <= 1'b0;
      i_r         <= '0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
        memw_r <= pwdata[MEMW_W-1:0];
      end
      // the result step below refills the register itself
      if (out_valid_r && out_ready && (state_r != S_OUT)) out_valid_r <= 1'b0;

      case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + MAW'(1);
          if (clr_cnt_r == MAW'(MEM_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            kind_r  <= in_data.kind;
            lit_r   <= in_data.literal;
            st_r    <= ST_OK;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          i_r    <= '0;
          give_r <= give_c;
          // fault priority: data under, data over, return under, return over
          if (kind_r > K_MEMSIZE) begin
            state_r <= S_OUT;
          end else if (dcnt_r < DCW'(need_c)) begin
            st_r    <= ST_DUNDER;
            state_r <= S_OUT;
          end else if (d_after > (DCW+1)'(DSTACK_DEPTH)) begin
            st_r    <= ST_DOVER;
            state_r <= S_OUT;
          end else if (rcnt_r < RCW'(rneed_c)) begin
            st_r    <= ST_RUNDER;
            state_r <= S_OUT;
          end else if (r_after > (RCW+1)'(RSTACK_DEPTH)) begin
            st_r    <= ST_ROVER;
            state_r <= S_OUT;
          end else begin
            state_r <= (need_c != '0) ? S_DRD : S_RRD;
          end
        end
        S_DRD: state_r <= S_DCAP;
        S_DCAP: begin
          p_r[i_r[1:0]] <= ds_rdata_r;
          if (i_r + 3'd1 < need_c) begin
            i_r     <= i_r + 3'd1;
            state_r <= S_DRD;
          end else begin
            i_r     <= '0;
            state_r <= S_RRD;
          end
        end
        S_RRD: state_r <= (i_r < {1'b0, rneed_c}) ? S_RCAP : S_EXEC;
        S_RCAP: begin
          q_r[i_r[0]] <= rs_rdata_r;
          i_r         <= i_r + 3'd1;
          state_r     <= S_RRD;
        end
        S_EXEC: begin
          case (kind_r)
            K_LOAD: begin
              if (addr_ok) state_r <= S_XCAP;
              else begin
                st_r    <= ST_BADADDR;
                state_r <= S_OUT;
              end
            end
            K_STORE: begin
              if (addr_ok) state_r <= S_COMP;
              else begin
                st_r    <= ST_BADADDR;
                state_r <= S_OUT;
              end
            end
            K_MUL: state_r <= S_MD;
            K_DIV: begin
              if (p_r[0] == '0) begin
                st_r    <= ST_DIVZERO;
                state_r <= S_OUT;
              end else state_r <= S_MD;
            end
            K_PICK: begin
              // index must address a cell below the one holding it
              if (pick_ok) state_r <= S_XCAP;
              else begin
                st_r    <= ST_DUNDER;
                state_r <= S_OUT;
              end
            end
            K_QDUP: begin
              if (p_r[0] != '0) begin
                if (dcnt_r == DCW'(DSTACK_DEPTH)) begin
                  st_r    <= ST_DOVER;
                  state_r <= S_OUT;
                end else begin
                  give_r  <= 3'd2;
                  state_r <= S_COMP;
                end
              end else state_r <= S_COMP;
            end
            default: state_r <= S_COMP;
          endcase
        end
        S_XCAP: begin
          x_r     <= (kind_r == K_LOAD) ? mem_rdata_r : ds_rdata_r;
          state_r <= S_COMP;
        end
        S_MD: begin
          if (md_rsp.done) begin
            x_r     <= md_res;
            state_r <= S_COMP;
          end
        end
        S_COMP: begin
          for (int k = 0; k < 6; k++) res_r[k] <= res_c[k];
          i_r     <= '0;
          state_r <= S_DWR;
        end
        S_DWR: begin
          if (i_r < give_r) i_r <= i_r + 3'd1;
          else begin
            dcnt_r  <= dcnt_r - DCW'(need_c) + DCW'(give_r);
            i_r     <= '0;
            state_r <= S_RWR;
          end
        end
        S_RWR: begin
          if (i_r < {1'b0, rgive_c}) i_r <= i_r + 3'd1;
          else begin
            rcnt_r  <= rcnt_r - RCW'(rneed_c) + RCW'(rgive_c);
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // result register frees up when the consumer takes the old one
          if (!out_valid_r || out_ready) begin
            out_r.status       <= st_r;
            out_r.emit_valid   <= ok_c && is_print;
            out_r.emit_is_char <= ok_c && (kind_r == K_PRINTC);
            out_r.emit_value   <= (ok_c && is_print) ? p_r[0] : '0;
            out_r.popped_zero  <= ok_c && (kind_r == K_BRTEST) && (p_r[0] == '0);
            out_r.data_depth   <= 9'(dcnt_r);
            out_valid_r        <= 1'b1;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == 1'b0) ? 32'(memw_r) : '0;

endmodule
`default_nettype wire

// ===== rtl/fsm_checker.sv =====
// port level checks of the forth core and their binding to the top level
`default_nettype none
module fsm_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire fsm_pkg::out_t out_data
);
  import fsm_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request in flight: the core never takes two back to back
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // a faulted request emits nothing and takes no branch
  a_fault_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |->
      !out_data.emit_valid && !out_data.popped_zero && !out_data.emit_is_char)
    else $error("fault with side data");

  // print and branch test are exclusive
  a_emit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.emit_valid |-> !out_data.popped_zero)
    else $error("print and branch flag together");

endmodule

bind forth_stack_machine_core fsm_checker u_fsm_checker (.*);
`default_nettype wire
